[rtl/core/fer_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the correctly rounded binary32 exponential.
package fer_pkg;

   localparam int FIX_W = 128;
   typedef logic [FIX_W-1:0] fix_type;

   // 1.0 and ln2 with 120 fraction bits
   localparam fix_type FIX_ONE = {64'h0100_0000_0000_0000, 64'h0};
   localparam fix_type LN2_FIX = {64'h00B1_7217_F7D1_CF79, 64'hABC9_E3B3_9803_F2F7};
   localparam logic [30:0] INV_LN2_Q30 = 31'd1549082005;

   localparam int SQUARINGS = 16;
   localparam int POLY_TOP = 6;
   localparam int POLY_TERMS = 5;
   localparam int MUL_LAT = 5;

   localparam logic [31:0] EXP_INF = 32'h7F80_0000;
   localparam logic [31:0] EXP_ONE = 32'h3F80_0000;
   localparam logic [31:0] QUIET_BIT = 32'h0040_0000;
   localparam logic [30:0] NAN_LIM = 31'h7F80_0000;
   localparam logic [30:0] OVF_LIM = 31'h42B2_0000;
   localparam logic [30:0] UNF_LIM = 31'h42D0_0000;
   localparam logic [30:0] TINY_LIM = 31'h3280_0000;
   localparam logic [7:0] EXP_ALIGN = 8'd94;

   localparam logic signed [9:0] K_MIN_NORM = -10'sd126;
   localparam logic signed [9:0] DROP_OFS = -10'sd29;
   localparam logic [7:0] DROP_MAX = 8'd121;

   typedef struct packed {
      logic signed [9:0] k;
      logic spec;
      logic [31:0] spec_val;
   } tail_type;

   typedef struct packed {
      fix_type val;
      tail_type tail;
   } carry_type;

endpackage

[rtl/core/fer_mul.sv]
`timescale 1ns / 1ps
// Pipelined 128x128 fixed-point multiplier, 120 fraction bits, truncated.
module fer_mul #(
   parameter int SIDE_W = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic in_valid,
   input  logic [127:0] a,
   input  logic [127:0] b,
   input  logic [SIDE_W-1:0] in_side,
   output logic out_valid,
   output logic [127:0] prod,
   output logic [SIDE_W-1:0] out_side
);
   localparam int LAT = fer_pkg::MUL_LAT;

   logic [63:0] pp_in [16];
   logic [63:0] pp_ff [16];
   logic [255:0] term [16];
   logic [255:0] l1_ff [8];
   logic [255:0] l2_ff [4];
   logic [255:0] l3_ff [2];
   logic [255:0] sum_all;
   logic [127:0] prod_ff;
   logic [LAT-1:0] v_ff;
   logic [SIDE_W-1:0] side_ff [LAT];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            pp_in[i*4+j] = 64'(a[i*32 +: 32]) * 64'(b[j*32 +: 32]);
            term[i*4+j] = 256'(pp_ff[i*4+j]) << (32 * (i + j));
         end
      end
      sum_all = l3_ff[0] + l3_ff[1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pp_ff <= pp_in;
         for (int m = 0; m < 8; m++) l1_ff[m] <= term[2*m] + term[2*m+1];
         for (int m = 0; m < 4; m++) l2_ff[m] <= l1_ff[2*m] + l1_ff[2*m+1];
         for (int m = 0; m < 2; m++) l3_ff[m] <= l2_ff[2*m] + l2_ff[2*m+1];
         prod_ff <= sum_all[247:120];
         side_ff[0] <= in_side;
         for (int s = 1; s < LAT; s++) side_ff[s] <= side_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[LAT-2:0], in_valid};
      end
   end

   assign out_valid = v_ff[LAT-1];
   assign prod = prod_ff;
   assign out_side = side_ff[LAT-1];

endmodule

[rtl/core/fer_div.sv]
`timescale 1ns / 1ps
// Pipelined truncating division of a 128-bit value by a small constant.
module fer_div #(
   parameter int DIVISOR = 3,
   parameter int SIDE_W = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic in_valid,
   input  logic [127:0] num,
   input  logic [SIDE_W-1:0] in_side,
   output logic out_valid,
   output logic [127:0] quot,
   output logic [SIDE_W-1:0] out_side
);
   localparam int STEP = 8;
   localparam int NST = 128 / STEP;
   localparam int RW = $clog2(DIVISOR);
   localparam int RSH = 20;
   localparam logic [RSH-1:0] RECIP = RSH'((2**RSH + DIVISOR - 1) / DIVISOR);

   logic [127:0] w_in [NST];
   logic [127:0] w_ff [NST];
   logic [RW-1:0] rem_in [NST];
   logic [RW-1:0] rem_ff [NST];
   logic [NST-1:0] v_ff;
   logic [SIDE_W-1:0] side_ff [NST];

   // divide one byte at a time: the remainder stays below the divisor, so the
   // quotient digit comes from a multiply by the scaled reciprocal
   function automatic logic [RW+127:0] div_steps(input logic [127:0] w,
                                                  input logic [RW-1:0] rem,
                                                  input int base);
      logic [127:0] wv;
      logic [6:0] pos;
      logic [RW+7:0] cur;
      logic [RW+RSH+7:0] prod;
      logic [7:0] qd;
      logic [RW+7:0] back;
      wv = w;
      pos = 7'(base);
      cur = {rem, w[pos -: STEP]};
      prod = (RW+RSH+8)'(cur) * (RW+RSH+8)'(RECIP);
      qd = prod[RSH+7:RSH];
      back = cur - (RW+8)'(qd) * (RW+8)'(DIVISOR);
      wv[pos -: STEP] = qd;
      return {back[RW-1:0], wv};
   endfunction

   always_comb begin
      {rem_in[0], w_in[0]} = div_steps(num, '0, 127);
      for (int s = 1; s < NST; s++) begin
         {rem_in[s], w_in[s]} = div_steps(w_ff[s-1], rem_ff[s-1], 127 - STEP * s);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w_ff <= w_in;
         rem_ff <= rem_in;
         side_ff[0] <= in_side;
         for (int s = 1; s < NST; s++) side_ff[s] <= side_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NST-2:0], in_valid};
      end
   end

   assign out_valid = v_ff[NST-1];
   assign quot = w_ff[NST-1];
   assign out_side = side_ff[NST-1];

endmodule

[rtl/core/fer_reduce.sv]
`timescale 1ns / 1ps
// Argument decode, special cases and reduction x = k*ln2 + r.
module fer_reduce (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic in_valid,
   input  logic [31:0] x_bits,
   output logic out_valid,
   output fer_pkg::fix_type s,
   output fer_pkg::tail_type tail
);
   logic [6:0] v_ff;
   logic [31:0] x1_ff;
   logic [30:0] ax;
   logic neg1;
   logic spec_in;
   logic [31:0] specv_in;
   logic [5:0] sh;
   logic [63:0] xf_in;
   logic [63:0] xf2_ff, xf3_ff, xf4_ff;
   logic neg2_ff, neg3_ff, neg4_ff, neg5_ff, neg6_ff;
   logic [5:1] spec_ff;
   logic [31:0] specv2_ff, specv3_ff, specv4_ff, specv5_ff, specv6_ff;
   logic [58:0] kprod;
   logic [8:0] kk_in, kk3_ff, kk4_ff, kk5_ff, kk6_ff;
   fer_pkg::fix_type lp_in, lp4_ff, xfull, r_in, r5_ff, r5_in, r6_ff, r6_in;
   logic [8:0] kk5_in, kk6_in;
   logic signed [9:0] k_in;
   fer_pkg::fix_type s7_ff;
   fer_pkg::tail_type tail7_ff;

   always_comb begin
      ax = x1_ff[30:0];
      neg1 = x1_ff[31];
      spec_in = 1'b1;
      specv_in = '0;
      if (ax > fer_pkg::NAN_LIM) begin
         specv_in = x1_ff | fer_pkg::QUIET_BIT;
      end else if (!neg1 && ax > fer_pkg::OVF_LIM) begin
         specv_in = fer_pkg::EXP_INF;
      end else if (neg1 && ax > fer_pkg::UNF_LIM) begin
         specv_in = '0;
      end else if (ax < fer_pkg::TINY_LIM) begin
         specv_in = fer_pkg::EXP_ONE;
      end else begin
         spec_in = 1'b0;
      end
      sh = 6'(ax[30:23] - fer_pkg::EXP_ALIGN);
      xf_in = 64'({1'b1, ax[22:0]}) << sh;

      kprod = 59'(xf2_ff[63:36]) * 59'(fer_pkg::INV_LN2_Q30);
      kk_in = kprod[58:50] + 9'(neg2_ff);

      lp_in = fer_pkg::LN2_FIX * fer_pkg::fix_type'(kk3_ff);

      xfull = {xf4_ff, 64'h0};
      r_in = neg4_ff ? lp4_ff - xfull : xfull - lp4_ff;

      r5_in = r5_ff;
      kk5_in = kk5_ff;
      if (r5_ff[127]) begin
         r5_in = r5_ff + fer_pkg::LN2_FIX;
         kk5_in = neg5_ff ? kk5_ff + 9'd1 : kk5_ff - 9'd1;
      end

      r6_in = r6_ff;
      kk6_in = kk6_ff;
      if (!(r6_ff < fer_pkg::LN2_FIX)) begin
         r6_in = r6_ff - fer_pkg::LN2_FIX;
         kk6_in = neg6_ff ? kk6_ff - 9'd1 : kk6_ff + 9'd1;
      end
      k_in = neg6_ff ? -$signed(10'(kk6_in)) : $signed(10'(kk6_in));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff <= x_bits;
         xf2_ff <= xf_in;  neg2_ff <= neg1;    specv2_ff <= specv_in;
         xf3_ff <= xf2_ff; neg3_ff <= neg2_ff; specv3_ff <= specv2_ff; kk3_ff <= kk_in;
         xf4_ff <= xf3_ff; neg4_ff <= neg3_ff; specv4_ff <= specv3_ff; kk4_ff <= kk3_ff;
         lp4_ff <= lp_in;
         r5_ff <= r_in; neg5_ff <= neg4_ff; specv5_ff <= specv4_ff; kk5_ff <= kk4_ff;
         r6_ff <= r5_in; neg6_ff <= neg5_ff; specv6_ff <= specv5_ff; kk6_ff <= kk5_in;
         s7_ff <= r6_in >> 16;
         tail7_ff.k <= k_in;
         tail7_ff.spec <= spec_ff[5];
         tail7_ff.spec_val <= specv6_ff;
         spec_ff <= {spec_ff[4:1], spec_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[5:0], in_valid};
      end
   end

   assign out_valid = v_ff[6];
   assign s = s7_ff;
   assign tail = tail7_ff;

endmodule

[rtl/core/fer_round.sv]
`timescale 1ns / 1ps
// Normalize, round to nearest even and pack the binary32 result.
module fer_round (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic in_valid,
   input  fer_pkg::fix_type e,
   input  fer_pkg::tail_type tail,
   output logic out_valid,
   output logic [31:0] y_bits
);
   logic [2:0] v_ff;
   fer_pkg::fix_type m_raw, m_in, m1_ff, shq, shr, mask;
   logic signed [9:0] k_in, k1_ff, k2_ff, drop_s;
   fer_pkg::tail_type t1_ff, t2_ff;
   logic [7:0] drop;
   logic [25:0] q2_ff;
   logic rb2_ff, st2_ff, zero2_ff;
   logic [33:0] qr;
   logic [31:0] y_in, y_ff;

   always_comb begin
      m_raw = fer_pkg::FIX_ONE + e;
      m_in = m_raw;
      k_in = tail.k;
      if (|m_raw[127:121]) begin
         m_in = m_raw >> 1;
         k_in = tail.k + 10'sd1;
      end

      drop_s = (k1_ff < fer_pkg::K_MIN_NORM) ? fer_pkg::DROP_OFS - k1_ff : 10'sd97;
      drop = 8'(drop_s);
      shq = m1_ff >> drop;
      shr = m1_ff >> (drop - 8'd1);
      mask = (fer_pkg::fix_type'(1) << (drop - 8'd1)) - fer_pkg::fix_type'(1);

      qr = 34'(q2_ff) + 34'(rb2_ff && (st2_ff || q2_ff[0]));
      if (!(k2_ff < fer_pkg::K_MIN_NORM)) begin
         qr = qr + (34'($unsigned(10'(k2_ff + 10'sd126))) << 23);
      end
      if (t2_ff.spec) begin
         y_in = t2_ff.spec_val;
      end else if (zero2_ff) begin
         y_in = '0;
      end else if (qr >= 34'(fer_pkg::EXP_INF)) begin
         y_in = fer_pkg::EXP_INF;
      end else begin
         y_in = qr[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff <= m_in;
         k1_ff <= k_in;
         t1_ff <= tail;
         q2_ff <= shq[25:0];
         rb2_ff <= shr[0];
         st2_ff <= |(m1_ff & mask);
         zero2_ff <= drop > fer_pkg::DROP_MAX;
         k2_ff <= k1_ff;
         t2_ff <= t1_ff;
         y_ff <= y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[1:0], in_valid};
      end
   end

   assign out_valid = v_ff[2];
   assign y_bits = y_ff;

endmodule

[rtl/core/float_exp_correctly_rounded.sv]
`timescale 1ns / 1ps
// Top level: correctly rounded binary32 exp(x), one transaction per cycle while not stalled.
//
// Usage:
//   Present a binary32 bit pattern on req_x_bits with req_valid; the
//   transaction is taken on a clock edge where req_valid and req_ready are
//   both high. Results leave in the same order on rsp_y_bits with rsp_valid
//   and are taken when rsp_ready is high.
//   The path from input transaction to rsp_valid has 7 reduction
//   stages, five series terms of 22 stages each (5-stage multiplier, 16-stage
//   constant divider, 1 add), a 5-stage multiply, sixteen squarings of 6
//   stages each, and 3 rounding stages. Throughput is one transaction per
//   cycle while the receiver does not stall; the 128x128 multiplier, split
//   into 32x32 partial products and an adder tree, sets the stage count.
//   When the receiver stalls, the whole pipeline holds: req_ready drops in
//   the same cycle as a stalled result, and no transaction is lost or
//   repeated. Synchronous reset clears all valid bits; payload registers are
//   left as they are.
module float_exp_correctly_rounded (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [31:0] req_x_bits,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [31:0] rsp_y_bits
);
   localparam int NTERM = fer_pkg::POLY_TERMS;
   localparam int NSQ = fer_pkg::SQUARINGS;

   logic adv;
   logic red_v;
   fer_pkg::fix_type red_s;
   fer_pkg::tail_type red_tail;

   logic poly_v [NTERM+1];
   fer_pkg::fix_type poly_t [NTERM+1];
   fer_pkg::carry_type poly_c [NTERM+1];

   logic sq_v [NSQ+1];
   fer_pkg::fix_type sq_e [NSQ+1];
   fer_pkg::tail_type sq_tail [NSQ+1];

   // advance whenever the output register is empty or being drained
   assign adv = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   fer_reduce u_reduce (
      .clock(clock), .reset(reset), .en(adv), .in_valid(req_valid),
      .x_bits(req_x_bits), .out_valid(red_v), .s(red_s), .tail(red_tail)
   );

   assign poly_v[0] = red_v;
   assign poly_t[0] = fer_pkg::FIX_ONE;
   assign poly_c[0] = '{val: red_s, tail: red_tail};

   // Horner form of the series: t <- 1 + (s*t)/n for n = 6 down to 2
   for (genvar g = 0; g < NTERM; g++) begin : g_poly
      logic m_v, d_v, v_ff;
      fer_pkg::fix_type m_p, d_q, t_ff;
      fer_pkg::carry_type m_c, d_c, c_ff;

      fer_mul #(.SIDE_W($bits(fer_pkg::carry_type))) u_mul (
         .clock(clock), .reset(reset), .en(adv), .in_valid(poly_v[g]),
         .a(poly_c[g].val), .b(poly_t[g]), .in_side(poly_c[g]),
         .out_valid(m_v), .prod(m_p), .out_side(m_c)
      );

      fer_div #(.DIVISOR(fer_pkg::POLY_TOP - g),
                .SIDE_W($bits(fer_pkg::carry_type))) u_div (
         .clock(clock), .reset(reset), .en(adv), .in_valid(m_v),
         .num(m_p), .in_side(m_c),
         .out_valid(d_v), .quot(d_q), .out_side(d_c)
      );

      always_ff @(posedge clock) begin
         if (adv) begin
            t_ff <= fer_pkg::FIX_ONE + d_q;
            c_ff <= d_c;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (adv) begin
            v_ff <= d_v;
         end
      end

      assign poly_v[g+1] = v_ff;
      assign poly_t[g+1] = t_ff;
      assign poly_c[g+1] = c_ff;
   end

   // e = s*t, so that 1 + e approximates exp(r / 2^16)
   fer_mul #(.SIDE_W($bits(fer_pkg::tail_type))) u_emul (
      .clock(clock), .reset(reset), .en(adv), .in_valid(poly_v[NTERM]),
      .a(poly_c[NTERM].val), .b(poly_t[NTERM]), .in_side(poly_c[NTERM].tail),
      .out_valid(sq_v[0]), .prod(sq_e[0]), .out_side(sq_tail[0])
   );

   // square 1+e sixteen times: e <- 2e + e^2
   for (genvar g = 0; g < NSQ; g++) begin : g_sq
      logic m_v, v_ff;
      fer_pkg::fix_type m_p, e_ff;
      fer_pkg::carry_type side_in, m_c;
      fer_pkg::tail_type tail_ff;

      assign side_in = '{val: sq_e[g], tail: sq_tail[g]};

      fer_mul #(.SIDE_W($bits(fer_pkg::carry_type))) u_mul (
         .clock(clock), .reset(reset), .en(adv), .in_valid(sq_v[g]),
         .a(sq_e[g]), .b(sq_e[g]), .in_side(side_in),
         .out_valid(m_v), .prod(m_p), .out_side(m_c)
      );

      always_ff @(posedge clock) begin
         if (adv) begin
            e_ff <= {m_c.val[126:0], 1'b0} + m_p;
            tail_ff <= m_c.tail;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (adv) begin
            v_ff <= m_v;
         end
      end

      assign sq_v[g+1] = v_ff;
      assign sq_e[g+1] = e_ff;
      assign sq_tail[g+1] = tail_ff;
   end

   fer_round u_round (
      .clock(clock), .reset(reset), .en(adv), .in_valid(sq_v[NSQ]),
      .e(sq_e[NSQ]), .tail(sq_tail[NSQ]),
      .out_valid(rsp_valid), .y_bits(rsp_y_bits)
   );

endmodule

[rtl/core/fer_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the exponential block, bound to the top level.
module fer_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic [31:0] req_x_bits,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [31:0] rsp_y_bits
);
   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_y_bits))
      else $error("result changed while stalled");

   // input side is open exactly when the output register can move
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("ready does not follow output stall");

   // reset empties the pipeline
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // exp(x) is never negative; only a NaN can carry a sign
   a_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_y_bits[31] |-> rsp_y_bits[30:23] == 8'hFF)
      else $error("negative non-NaN result");

endmodule

bind float_exp_correctly_rounded fer_checker u_fer_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .req_x_bits(req_x_bits), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_y_bits(rsp_y_bits)
);

[sim/testbench.sv]
`timescale 1ns / 1ps
// Testbench for the correctly rounded binary32 exponential: directed and random arguments.
module testbench;

   // Predict exp(x) bit for bit and track the results still owed by the block.
   class exp_scoreboard;
      logic [31:0] owed_q[$];
      int errors = 0;

      // Fixed-point product with 120 fraction bits, truncated.
      function fer_pkg::fix_type fix_mul(fer_pkg::fix_type a, fer_pkg::fix_type b);
         logic [255:0] p;
         p = {128'h0, a} * {128'h0, b};
         return p[247:120];
      endfunction

      function logic [31:0] exp_rounded(logic [31:0] x);
         logic [30:0] ax;
         logic neg;
         fer_pkg::fix_type xf, r, s, t, e, m, keep_mask;
         logic [63:0] prod;
         logic [63:0] q;
         int kk, k, drop, n;
         logic rnd, sticky;
         ax = x[30:0];
         neg = x[31];
         if (ax > fer_pkg::NAN_LIM) return x | fer_pkg::QUIET_BIT;
         if (!neg && ax > fer_pkg::OVF_LIM) return fer_pkg::EXP_INF;
         if (neg && ax > fer_pkg::UNF_LIM) return 32'h0;
         if (ax < fer_pkg::TINY_LIM) return fer_pkg::EXP_ONE;
         // |x| aligned to 120 fraction bits
         xf = fer_pkg::fix_type'({1'b1, ax[22:0]}) << (int'(ax[30:23]) - 94 + 64);
         prod = {28'h0, xf[127:100]} * {33'h0, fer_pkg::INV_LN2_Q30};
         kk = int'(prod >> 50);
         if (neg) begin
            kk += 1;
            r = fer_pkg::LN2_FIX * fer_pkg::fix_type'(kk) - xf;
         end else begin
            r = xf - fer_pkg::LN2_FIX * fer_pkg::fix_type'(kk);
         end
         // pull the remainder into [0, ln2)
         if (r[127]) begin
            r = r + fer_pkg::LN2_FIX;
            kk += neg ? 1 : -1;
         end
         if (r >= fer_pkg::LN2_FIX) begin
            r = r - fer_pkg::LN2_FIX;
            kk += neg ? -1 : 1;
         end
         k = neg ? -kk : kk;
         s = r >> fer_pkg::SQUARINGS;
         t = fer_pkg::FIX_ONE;
         for (n = fer_pkg::POLY_TOP; n >= 2; n--)
            t = fer_pkg::FIX_ONE + fix_mul(s, t) / fer_pkg::fix_type'(n);
         e = fix_mul(s, t);
         for (n = 0; n < fer_pkg::SQUARINGS; n++)
            e = e + e + fix_mul(e, e);
         m = fer_pkg::FIX_ONE + e;
         if (|m[127:121]) begin
            m = m >> 1;
            k += 1;
         end
         drop = 97;
         if (k < -126) drop += -126 - k;
         if (drop > 121) return 32'h0;
         q = 64'(m >> drop);
         rnd = m[drop-1];
         keep_mask = (fer_pkg::fix_type'(1) << (drop - 1)) - 1;
         sticky = (m & keep_mask) != 0;
         if (rnd && (sticky || q[0])) q++;
         if (k >= -126) q += 64'(k + 126) << 23;
         if (q >= 64'(fer_pkg::EXP_INF)) return fer_pkg::EXP_INF;
         return q[31:0];
      endfunction

      function void note_argument(logic [31:0] x);
         owed_q.push_back(exp_rounded(x));
      endfunction

      function void check_result(logic [31:0] y);
         logic [31:0] want;
         if (owed_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result y=%08h", y);
            return;
         end
         want = owed_q.pop_front();
         if (y !== want) begin
            errors++;
            if (errors <= 10) $display("y_bits mismatch: expected %08h actual %08h", want, y);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [31:0] req_x_bits = 32'h0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [31:0] rsp_y_bits;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   exp_scoreboard sb = new();

   always #5 clock = ~clock;

   float_exp_correctly_rounded u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_x_bits(req_x_bits),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_y_bits(rsp_y_bits)
   );

   // Present one argument, optionally after an idle gap, and hold it until taken.
   task automatic send_argument(logic [31:0] x);
      @(negedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_x_bits <= x;
      do @(posedge clock); while (!req_ready);
      sb.note_argument(x);
   endtask

   // Draw an argument: mostly inside the range where the core computes,
   // the rest spread over the whole word.
   function automatic logic [31:0] pick_argument();
      logic [31:0] x;
      x = $urandom();
      case ($urandom_range(9))
         0, 1, 2: ;
         3: x[30:0] = $urandom_range(32'h42A8_0000, 32'h42D0_2000);
         default: x[30:0] = $urandom_range(32'h3280_0000, 32'h42D0_0000);
      endcase
      return x;
   endfunction

   // Response side: check each accepted result, then redraw rsp_ready.
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_y_bits);
         @(negedge clock);
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Hard stop in case the pipeline hangs.
   initial begin
      #5000000;
      $display("Regression FAIL");
      $finish;
   end

   logic [31:0] directed_args[] = '{
      32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h807F_FFFF,
      32'h327F_FFFF, 32'h3280_0000, 32'hB280_0000, 32'h3F80_0000,
      32'hBF80_0000, 32'h3F31_7218, 32'h42B1_7218, 32'h42B2_0000,
      32'h42B2_0001, 32'hC2AE_AC50, 32'hC2CF_FFFF, 32'hC2D0_0000,
      32'hC2D0_0001, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
      32'h7F80_0001, 32'hFFBF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
      32'hC2BA_0000
   };

   initial begin
      int phase, i;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Special cases and field extremes, no idling.
      foreach (directed_args[i]) send_argument(directed_args[i]);

      // Three random phases: receiver stalls, then sender idles, then neither.
      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 80 : 0;
         recv_stall_pct = (phase == 0) ? 80 : (phase == 1) ? 7 : 0;
         for (i = 0; i < 200; i++) send_argument(pick_argument());
      end
      @(negedge clock);
      req_valid <= 1'b0;

      // Drain, then give stray results a pipeline's worth of time to show up.
      while (sb.owed_q.size() != 0) @(posedge clock);
      repeat (fer_pkg::MUL_LAT * 50) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/core/fer_pkg.sv
rtl/core/fer_mul.sv
rtl/core/fer_div.sv
rtl/core/fer_reduce.sv
rtl/core/fer_round.sv
rtl/core/float_exp_correctly_rounded.sv
rtl/core/fer_checker.sv
sim/testbench.sv
